### sv/imhq_pkg.sv
`timescale 1ns / 1ps

package imhq_pkg;

	// sizes
	localparam int CAPACITY  = 1024;
	localparam int KEY_BITS  = 20;
	localparam int ID_BITS   = 10;
	localparam int ID_COUNT  = 2 ** ID_BITS;
	localparam int SLOT_BITS = $clog2(CAPACITY + 1);
	localparam int ADDR_BITS = $clog2(CAPACITY);

	// operation kinds
	localparam logic [1:0] K_INSERT   = 2'd0;
	localparam logic [1:0] K_DECREASE = 2'd1;
	localparam logic [1:0] K_EXTRACT  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_PRESENT = 2'd2;
	localparam logic [1:0] ST_ABSENT  = 2'd3;

	// datapath commands
	localparam logic [4:0] C_NOP       = 5'd0;
	localparam logic [4:0] C_CLEAR     = 5'd1;
	localparam logic [4:0] C_ACCEPT    = 5'd2;
	localparam logic [4:0] C_INS       = 5'd3;
	localparam logic [4:0] C_DEC       = 5'd4;
	localparam logic [4:0] C_STAT      = 5'd5;
	localparam logic [4:0] C_RD_PARENT = 5'd6;
	localparam logic [4:0] C_RD_KEY    = 5'd7;
	localparam logic [4:0] C_UP_MOVE   = 5'd8;
	localparam logic [4:0] C_PLACE     = 5'd9;
	localparam logic [4:0] C_RD_TOP    = 5'd10;
	localparam logic [4:0] C_TOP       = 5'd11;
	localparam logic [4:0] C_SINK_INIT = 5'd12;
	localparam logic [4:0] C_RD_LEFT   = 5'd13;
	localparam logic [4:0] C_SAVE_L    = 5'd14;
	localparam logic [4:0] C_MOVE      = 5'd15;
	localparam logic [4:0] C_LOAD_OUT  = 5'd16;

	typedef struct packed {
		logic [4:0] code;
		logic [1:0] status;
		logic       right;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       slot_zero;
		logic       full;
		logic       empty;
		logic       cnt_one;
		logic       at_root;
		logic       l_over;
		logic       r_over;
		logic       k_lt_rd;
		logic       rd_lt_k;
		logic       lk_lt_k;
		logic       lk_lt_rd;
		logic       clr_last;
		logic       out_busy;
	} stat_t;

endpackage

### sv/imhq_ram.sv
`timescale 1ns / 1ps

module imhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/imhq_datapath.sv
`timescale 1ns / 1ps

module imhq_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  imhq_pkg::cmd_t                 cmd,
	input  logic [1:0]                     kind,
	input  logic [imhq_pkg::ID_BITS-1:0]   element_id,
	input  logic [imhq_pkg::KEY_BITS-1:0]  new_key,
	output imhq_pkg::stat_t                stat,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [imhq_pkg::ID_BITS-1:0]   out_id,
	output logic [imhq_pkg::KEY_BITS-1:0]  out_key,
	output logic [imhq_pkg::SLOT_BITS-1:0] occupancy
);
	import imhq_pkg::*;

	// control registers
	logic [SLOT_BITS-1:0] cnt_q;
	logic [ID_BITS-1:0]   clr_q;
	logic                 out_valid_q;

	// working registers
	logic [1:0]           kind_q;
	logic [ID_BITS-1:0]   id_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [SLOT_BITS-1:0] pos_q;
	logic [ID_BITS-1:0]   hid_q;
	logic [ID_BITS-1:0]   lid_q;
	logic [KEY_BITS-1:0]  lkey_q;
	logic [1:0]           res_status_q;
	logic [ID_BITS-1:0]   res_id_q;
	logic [KEY_BITS-1:0]  res_key_q;
	logic [1:0]           status_q;
	logic [ID_BITS-1:0]   out_id_q;
	logic [KEY_BITS-1:0]  out_key_q;
	logic [SLOT_BITS-1:0] occ_q;

	// memory ports
	logic                 heap_we;
	logic [ADDR_BITS-1:0] heap_waddr;
	logic [ID_BITS-1:0]   heap_wdata;
	logic [ADDR_BITS-1:0] heap_raddr;
	logic [ID_BITS-1:0]   heap_rd;
	logic                 key_we;
	logic [KEY_BITS-1:0]  key_rd;
	logic                 slot_we;
	logic [ID_BITS-1:0]   slot_waddr;
	logic [SLOT_BITS-1:0] slot_wdata;
	logic [SLOT_BITS-1:0] slot_rd;

	logic [SLOT_BITS:0]   l_pos;
	logic [SLOT_BITS:0]   r_pos;
	logic [ID_BITS-1:0]   move_id;

	assign l_pos   = {pos_q, 1'b0};
	assign r_pos   = {pos_q, 1'b1};
	assign move_id = cmd.right ? hid_q : lid_q;

	// heap read address per command
	always_comb begin
		case (cmd.code)
			C_RD_PARENT: heap_raddr = ADDR_BITS'((pos_q >> 1) - 1'b1);
			C_TOP:       heap_raddr = ADDR_BITS'(cnt_q - 1'b1);
			C_RD_LEFT:   heap_raddr = ADDR_BITS'(l_pos - 1'b1);
			C_SAVE_L:    heap_raddr = ADDR_BITS'(l_pos);
			default:     heap_raddr = '0;
		endcase
	end

	// heap writes
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = ADDR_BITS'(pos_q - 1'b1);
		heap_wdata = id_q;
		case (cmd.code)
			C_PLACE: begin
				heap_we = 1'b1;
			end
			C_UP_MOVE: begin
				heap_we    = 1'b1;
				heap_wdata = hid_q;
			end
			C_MOVE: begin
				heap_we    = 1'b1;
				heap_wdata = move_id;
			end
			default: ;
		endcase
	end

	// position table writes
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = id_q;
		slot_wdata = pos_q;
		case (cmd.code)
			C_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
			end
			C_PLACE: begin
				slot_we = 1'b1;
			end
			C_UP_MOVE: begin
				slot_we    = 1'b1;
				slot_waddr = hid_q;
			end
			C_MOVE: begin
				slot_we    = 1'b1;
				slot_waddr = move_id;
			end
			C_TOP: begin
				slot_we    = 1'b1;
				slot_waddr = hid_q;
				slot_wdata = '0;
			end
			default: ;
		endcase
	end

	assign key_we = (cmd.code == C_INS) || (cmd.code == C_DEC);

	imhq_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_heap (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (heap_wdata),
		.raddr (heap_raddr),
		.rdata (heap_rd)
	);

	imhq_ram #(.WIDTH(KEY_BITS), .DEPTH(ID_COUNT)) u_key (
		.clk   (clk),
		.we    (key_we),
		.waddr (id_q),
		.wdata (key_q),
		.raddr (heap_rd),
		.rdata (key_rd)
	);

	imhq_ram #(.WIDTH(SLOT_BITS), .DEPTH(ID_COUNT)) u_slot (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (element_id),
		.rdata (slot_rd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.code)
				C_CLEAR: clr_q <= clr_q + 1'b1;
				C_INS:   cnt_q <= cnt_q + 1'b1;
				C_TOP:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
			if (cmd.code == C_LOAD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.code)
			C_ACCEPT: begin
				kind_q       <= kind;
				id_q         <= element_id;
				key_q        <= new_key;
				res_status_q <= ST_OK;
				res_id_q     <= '0;
				res_key_q    <= '0;
			end
			C_INS:       pos_q <= cnt_q + 1'b1;
			C_DEC:       pos_q <= slot_rd;
			C_STAT:      res_status_q <= cmd.status;
			C_RD_KEY:    hid_q <= heap_rd;
			C_UP_MOVE:   pos_q <= pos_q >> 1;
			C_TOP: begin
				res_id_q  <= hid_q;
				res_key_q <= key_rd;
			end
			C_SINK_INIT: begin
				id_q  <= hid_q;
				key_q <= key_rd;
				pos_q <= SLOT_BITS'(1);
			end
			C_SAVE_L: begin
				lid_q  <= hid_q;
				lkey_q <= key_rd;
			end
			C_MOVE:      pos_q <= cmd.right ? SLOT_BITS'(r_pos) : SLOT_BITS'(l_pos);
			C_LOAD_OUT: begin
				status_q  <= res_status_q;
				out_id_q  <= res_id_q;
				out_key_q <= res_key_q;
				occ_q     <= cnt_q;
			end
			default: ;
		endcase
	end

	// status toward the controller
	always_comb begin
		stat.kind      = kind_q;
		stat.slot_zero = (slot_rd == '0);
		stat.full      = (cnt_q == SLOT_BITS'(CAPACITY));
		stat.empty     = (cnt_q == '0);
		stat.cnt_one   = (cnt_q == SLOT_BITS'(1));
		stat.at_root   = (pos_q == SLOT_BITS'(1));
		stat.l_over    = (l_pos > {1'b0, cnt_q});
		stat.r_over    = (r_pos > {1'b0, cnt_q});
		stat.k_lt_rd   = (key_q < key_rd);
		stat.rd_lt_k   = (key_rd < key_q);
		stat.lk_lt_k   = (lkey_q < key_q);
		stat.lk_lt_rd  = (lkey_q < key_rd);
		stat.clr_last  = (clr_q == ID_BITS'(ID_COUNT - 1));
		stat.out_busy  = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_id    = out_id_q;
	assign out_key   = out_key_q;
	assign occupancy = occ_q;

endmodule

### sv/imhq_ctrl.sv
`timescale 1ns / 1ps

module imhq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  imhq_pkg::stat_t stat,
	output imhq_pkg::cmd_t  cmd
);
	import imhq_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_UP    = 4'd3;
	localparam logic [3:0] S_UP_P  = 4'd4;
	localparam logic [3:0] S_UP_K  = 4'd5;
	localparam logic [3:0] S_X1    = 4'd6;
	localparam logic [3:0] S_X2    = 4'd7;
	localparam logic [3:0] S_X3    = 4'd8;
	localparam logic [3:0] S_X4    = 4'd9;
	localparam logic [3:0] S_DN    = 4'd10;
	localparam logic [3:0] S_DN_L  = 4'd11;
	localparam logic [3:0] S_DN_LK = 4'd12;
	localparam logic [3:0] S_DN_L2 = 4'd13;
	localparam logic [3:0] S_DN_RK = 4'd14;
	localparam logic [3:0] S_DONE  = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and command
	always_comb begin
		state_d    = state_q;
		cmd.code   = C_NOP;
		cmd.status = ST_OK;
		cmd.right  = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.code = C_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = C_ACCEPT;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				state_d = S_DONE;
				case (stat.kind)
					K_INSERT: begin
						if (!stat.slot_zero || stat.full) begin
							cmd.code   = C_STAT;
							cmd.status = ST_PRESENT;
						end else begin
							cmd.code = C_INS;
							state_d  = S_UP;
						end
					end
					K_DECREASE: begin
						if (stat.slot_zero) begin
							cmd.code   = C_STAT;
							cmd.status = ST_ABSENT;
						end else begin
							cmd.code = C_DEC;
							state_d  = S_UP;
						end
					end
					K_EXTRACT: begin
						if (stat.empty) begin
							cmd.code   = C_STAT;
							cmd.status = ST_EMPTY;
						end else begin
							cmd.code = C_RD_TOP;
							state_d  = S_X1;
						end
					end
					default: ;
				endcase
			end
			// sift up: fetch parent id, then its key, then compare
			S_UP: begin
				if (stat.at_root) begin
					cmd.code = C_PLACE;
					state_d  = S_DONE;
				end else begin
					cmd.code = C_RD_PARENT;
					state_d  = S_UP_P;
				end
			end
			S_UP_P: begin
				cmd.code = C_RD_KEY;
				state_d  = S_UP_K;
			end
			S_UP_K: begin
				if (stat.k_lt_rd) begin
					cmd.code = C_UP_MOVE;
					state_d  = S_UP;
				end else begin
					cmd.code = C_PLACE;
					state_d  = S_DONE;
				end
			end
			// extract: root id, its key, then last entry to sink
			S_X1: begin
				cmd.code = C_RD_KEY;
				state_d  = S_X2;
			end
			S_X2: begin
				cmd.code = C_TOP;
				state_d  = stat.cnt_one ? S_DONE : S_X3;
			end
			S_X3: begin
				cmd.code = C_RD_KEY;
				state_d  = S_X4;
			end
			S_X4: begin
				cmd.code = C_SINK_INIT;
				state_d  = S_DN;
			end
			// sift down: left child, then right child, then choose
			S_DN: begin
				if (stat.l_over) begin
					cmd.code = C_PLACE;
					state_d  = S_DONE;
				end else begin
					cmd.code = C_RD_LEFT;
					state_d  = S_DN_L;
				end
			end
			S_DN_L: begin
				cmd.code = C_RD_KEY;
				state_d  = S_DN_LK;
			end
			S_DN_LK: begin
				cmd.code = C_SAVE_L;
				state_d  = S_DN_L2;
			end
			S_DN_L2: begin
				if (stat.r_over) begin
					if (stat.lk_lt_k) begin
						cmd.code = C_MOVE;
						state_d  = S_DN;
					end else begin
						cmd.code = C_PLACE;
						state_d  = S_DONE;
					end
				end else begin
					cmd.code = C_RD_KEY;
					state_d  = S_DN_RK;
				end
			end
			S_DN_RK: begin
				if (stat.lk_lt_k && stat.rd_lt_k) begin
					cmd.code  = C_MOVE;
					cmd.right = !stat.lk_lt_rd;
					state_d   = S_DN;
				end else if (stat.lk_lt_k) begin
					cmd.code = C_MOVE;
					state_d  = S_DN;
				end else if (stat.rd_lt_k) begin
					cmd.code  = C_MOVE;
					cmd.right = 1'b1;
					state_d   = S_DN;
				end else begin
					cmd.code = C_PLACE;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.code = C_LOAD_OUT;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/indexed_min_heap_queue.sv
`timescale 1ns / 1ps

// channel | direction | handshake          | fields
// in      | input     | in_valid/in_stall  | kind, element_id, new_key
// out     | output    | out_valid/out_stall| status, out_id, out_key, occupancy
//
// one word at a time: accept, check, result; sift up reads the parent id,
// its key and compares per level, extract reads root and last entry, then sift down; one
// memory read per cycle on the heap and key memories
// after reset a clearing pass zeroes every entry of the position table
// a finished result waits in the output register while the next word runs

module indexed_min_heap_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [imhq_pkg::ID_BITS-1:0]   element_id,
	input  logic [imhq_pkg::KEY_BITS-1:0]  new_key,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [imhq_pkg::ID_BITS-1:0]   out_id,
	output logic [imhq_pkg::KEY_BITS-1:0]  out_key,
	output logic [imhq_pkg::SLOT_BITS-1:0] occupancy
);
	import imhq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	imhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	imhq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.element_id (element_id),
		.new_key    (new_key),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_id     (out_id),
		.out_key    (out_key),
		.occupancy  (occupancy)
	);

endmodule

### tb/sv/indexed_min_heap_queue_test.sv
`timescale 1ns / 1ps

module indexed_min_heap_queue_test;
	import imhq_pkg::*;

	localparam logic [1:0] K_UNUSED = 2'd3;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]          status;
		logic [ID_BITS-1:0]  id;
		logic [KEY_BITS-1:0] key;
		logic [SLOT_BITS-1:0] occ;
	} heap_result_t;

	typedef struct {
		logic [1:0]          kind;
		logic [ID_BITS-1:0]  id;
		logic [KEY_BITS-1:0] key;
		bit                  typed;
		heap_result_t        res;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic [ID_BITS-1:0] element_id = '0;
	logic [KEY_BITS-1:0] new_key = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [ID_BITS-1:0] out_id;
	logic [KEY_BITS-1:0] out_key;
	logic [SLOT_BITS-1:0] occupancy;

	indexed_min_heap_queue i_dut (.*);

	// heap shadow
	logic [ID_BITS-1:0]   slot_id [1:CAPACITY];
	logic [KEY_BITS-1:0]  id_key [ID_COUNT];
	logic [SLOT_BITS-1:0] id_slot [ID_COUNT];
	int unsigned          fill;

	heap_result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 0;

	initial forever #5 clk = ~clk;

	// sift up from pos
	function automatic void heap_lift(logic [ID_BITS-1:0] id, int unsigned pos);
		logic [KEY_BITS-1:0] k;
		k = id_key[id];
		while (pos > 1 && k < id_key[slot_id[pos / 2]]) begin
			slot_id[pos] = slot_id[pos / 2];
			id_slot[slot_id[pos]] = SLOT_BITS'(pos);
			pos = pos / 2;
		end
		slot_id[pos] = id;
		id_slot[id] = SLOT_BITS'(pos);
	endfunction

	// sift down the root
	function automatic void heap_sink();
		int unsigned pos, l, r, c;
		logic [ID_BITS-1:0] id;
		logic [KEY_BITS-1:0] k, lk, rk;
		pos = 1;
		id = slot_id[1];
		k = id_key[id];
		forever begin
			l = pos * 2;
			r = l + 1;
			if (l > fill) break;
			lk = id_key[slot_id[l]];
			if (r > fill) begin
				if (lk < k) c = l;
				else break;
			end else begin
				rk = id_key[slot_id[r]];
				if (lk < k && rk < k) c = (lk < rk) ? l : r;
				else if (lk < k) c = l;
				else if (rk < k) c = r;
				else break;
			end
			slot_id[pos] = slot_id[c];
			id_slot[slot_id[pos]] = SLOT_BITS'(pos);
			pos = c;
		end
		slot_id[pos] = id;
		id_slot[id] = SLOT_BITS'(pos);
	endfunction

	// apply one operation to the shadow heap
	function automatic heap_result_t heap_apply(logic [1:0] k, logic [ID_BITS-1:0] id,
			logic [KEY_BITS-1:0] key);
		heap_result_t r;
		logic [ID_BITS-1:0] top;
		r = '0;
		case (k)
			K_INSERT: begin
				if (id_slot[id] != 0 || fill >= CAPACITY) r.status = ST_PRESENT;
				else begin
					id_key[id] = key;
					fill++;
					heap_lift(id, fill);
				end
			end
			K_DECREASE: begin
				if (id_slot[id] == 0) r.status = ST_ABSENT;
				else begin
					id_key[id] = key;
					heap_lift(id, id_slot[id]);
				end
			end
			K_EXTRACT: begin
				if (fill == 0) r.status = ST_EMPTY;
				else begin
					top = slot_id[1];
					r.id = top;
					r.key = id_key[top];
					id_slot[top] = '0;
					if (fill > 1) begin
						slot_id[1] = slot_id[fill];
						id_slot[slot_id[1]] = SLOT_BITS'(1);
						fill--;
						heap_sink();
					end else fill = 0;
				end
			end
			default: ;
		endcase
		r.occ = SLOT_BITS'(fill);
		return r;
	endfunction

	// gap length: mostly short, sometimes long
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drive one word and wait for acceptance
	task automatic send_word(logic [1:0] k, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key);
		int g;
		bit taken;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		element_id <= id;
		new_key <= key;
		// stall is sampled away from the edge that accepts
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
	endtask

	// send a word predicted by the shadow heap
	task automatic send_op(logic [1:0] k, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key);
		pending_results.push_back(heap_apply(k, id, key));
		send_word(k, id, key);
	endtask

	// random id that is present in the heap
	function automatic logic [ID_BITS-1:0] present_id();
		return slot_id[$urandom_range(1, fill)];
	endfunction

	// stimulus
	initial begin
		op_row_t rows[$];
		op_row_t row;
		int choice;
		logic [ID_BITS-1:0] id;
		for (int i = 0; i < ID_COUNT; i++) id_slot[i] = '0;
		fill = 0;
		// directed table
		rows.push_back('{K_EXTRACT, 10'd0, 20'd0, 1, '{ST_EMPTY, '0, '0, 11'd0}});
		rows.push_back('{K_DECREASE, 10'd5, 20'd1, 1, '{ST_ABSENT, '0, '0, 11'd0}});
		rows.push_back('{K_UNUSED, 10'h3ff, 20'hfffff, 1, '{ST_OK, '0, '0, 11'd0}});
		rows.push_back('{K_INSERT, 10'h3ff, 20'hfffff, 1, '{ST_OK, '0, '0, 11'd1}});
		rows.push_back('{K_INSERT, 10'h3ff, 20'd0, 1, '{ST_PRESENT, '0, '0, 11'd1}});
		rows.push_back('{K_INSERT, 10'd0, 20'd0, 1, '{ST_OK, '0, '0, 11'd2}});
		rows.push_back('{K_INSERT, 10'd1, 20'd0, 0, '{default: '0}});
		rows.push_back('{K_INSERT, 10'd2, 20'd7, 0, '{default: '0}});
		rows.push_back('{K_INSERT, 10'd3, 20'd7, 0, '{default: '0}});
		rows.push_back('{K_INSERT, 10'd4, 20'd3, 0, '{default: '0}});
		rows.push_back('{K_DECREASE, 10'd2, 20'd1, 0, '{default: '0}});
		rows.push_back('{K_DECREASE, 10'd4, 20'd9, 0, '{default: '0}});
		rows.push_back('{K_UNUSED, 10'd1, 20'd1, 0, '{default: '0}});
		for (int i = 0; i < 8; i++)
			rows.push_back('{K_EXTRACT, 10'h2aa, 20'h55555, 0, '{default: '0}});
		rows.push_back('{K_DECREASE, 10'h3ff, 20'd2, 1, '{ST_ABSENT, '0, '0, 11'd0}});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i]) begin
			row = rows[i];
			if (row.typed) begin
				void'(heap_apply(row.kind, row.id, row.key));
				pending_results.push_back(row.res);
				send_word(row.kind, row.id, row.key);
			end else send_op(row.kind, row.id, row.key);
		end

		// build a deep heap with many equal keys, then drain it
		for (int i = 0; i < 256; i++)
			if (id_slot[i] == 0)
				send_op(K_INSERT, ID_BITS'(i), KEY_BITS'($urandom_range(0, 15)));
		send_op(K_INSERT, ID_BITS'($urandom()), KEY_BITS'($urandom()));
		for (int i = 0; i < 40; i++)
			send_op(K_DECREASE, present_id(), KEY_BITS'($urandom_range(0, 15)));
		while (fill > 0) send_op(K_EXTRACT, ID_BITS'($urandom()), KEY_BITS'($urandom()));

		// random mix: mostly legal ops on a small id set
		for (int n = 0; n < 640; n++) begin
			choice = $urandom_range(0, 99);
			id = ($urandom_range(0, 3) == 0) ? ID_BITS'($urandom()) :
				ID_BITS'($urandom_range(0, 63));
			if (choice < 40) send_op(K_INSERT, id, ($urandom_range(0, 1)) ?
				KEY_BITS'($urandom_range(0, 31)) : KEY_BITS'($urandom()));
			else if (choice < 60) send_op(K_DECREASE,
				(fill > 0 && choice < 55) ? present_id() : id,
				KEY_BITS'($urandom_range(0, 31)));
			else if (choice < 97)
				send_op(K_EXTRACT, ID_BITS'($urandom()), KEY_BITS'($urandom()));
			else send_op(K_UNUSED, ID_BITS'($urandom()), KEY_BITS'($urandom()));
		end
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// receiver stall pattern
	initial begin
		int g;
		forever begin
			g = gap_len();
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// result check
	always @(posedge clk) begin
		heap_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word status=%0d id=%0d key=%0d occ=%0d",
					$time, status, out_id, out_key, occupancy);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
					errors++;
				end
				if (out_id !== exp_r.id) begin
					$display("%0t: out_id expected %0d actual %0d", $time, exp_r.id, out_id);
					errors++;
				end
				if (out_key !== exp_r.key) begin
					$display("%0t: out_key expected %0d actual %0d", $time, exp_r.key, out_key);
					errors++;
				end
				if (occupancy !== exp_r.occ) begin
					$display("%0t: occupancy expected %0d actual %0d",
						$time, exp_r.occ, occupancy);
					errors++;
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		while (!(stim_done && pending_results.size() == 0) && cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= LIMIT) begin
			$display("DONE: errors detected");
		end else begin
			repeat (100) @(posedge clk);
			if (errors == 0 && pending_results.size() == 0) begin
				$display("DONE: 0 errors");
			end else begin
				$display("DONE: errors detected");
			end
		end
		$finish;
	end

endmodule
